// ===== design/skrs_pkg.sv =====
// Shared definitions for the sorted key range search block.
// Field widths, word layout, register indexes, opcodes and controller states.
// No dependencies.
package skrs_pkg;

    // Default sizing of the key table
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_WIDTH_DEF   = 32;

    // Fixed field widths
    localparam int OP_W     = 1;
    localparam int IDX_W    = 10;
    localparam int FKEY_W   = 32;
    localparam int RES_W    = 11;
    localparam int CNT_W    = 11;

    // Input word layout, lowest bit first
    localparam int IDX_LSB   = 0;
    localparam int EKEY_LSB  = IDX_LSB + IDX_W;
    localparam int RSTA_LSB  = EKEY_LSB + FKEY_W;
    localparam int REND_LSB  = RSTA_LSB + FKEY_W;
    localparam int S_TDATA_W = ((REND_LSB + FKEY_W + 7) / 8) * 8;

    // Result word layout
    localparam int FIRST_LSB = 0;
    localparam int LAST_LSB  = FIRST_LSB + RES_W;
    localparam int M_TDATA_W = ((LAST_LSB + RES_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECORD_COUNT = 1'b0,
        CFG_KEY_SIGNED   = 1'b1
    } cfg_reg_t;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE0,
        ST_EDGE1,
        ST_EDGE2,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // Controls from the sequencer to one bisection unit
    typedef struct packed {
        logic init;        // load bounds for a new query
        logic upd;         // read data for this unit is on the RAM output
        logic strict;      // 1: predicate key > k, 0: key >= k
        logic key_signed;  // two's complement ordering
    } bctl_t;

endpackage

// ===== design/skrs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Holds the key table. No dependencies.
module skrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/skrs_bisect.sv =====
// One bisection unit: holds the search window and steps it on each key read.
// Depends on skrs_pkg.
module skrs_bisect #(
    parameter int TABLE_DEPTH = skrs_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = skrs_pkg::KEY_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  skrs_pkg::bctl_t                    ctl,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]   n,
    input  logic [KEY_WIDTH-1:0]               key,
    input  logic [KEY_WIDTH-1:0]               rd_key,
    output logic                               active,
    output logic [$clog2(TABLE_DEPTH)-1:0]     mid_addr,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]   result
);
    import skrs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam logic [KEY_WIDTH-1:0] KEY_TOP = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    // lo_reg is the bisection low bound plus one, so it never goes negative
    logic [NW-1:0]        lo_reg, hi_reg;
    logic [NW:0]          mid_sum;
    logic [NW-1:0]        mid;
    logic [KEY_WIDTH-1:0] flip, key_x, rd_x;
    logic                 go_left;

    assign active  = hi_reg > lo_reg;
    assign mid_sum = {1'b0, hi_reg} + {1'b0, lo_reg} - {{NW{1'b0}}, 1'b1};
    assign mid     = mid_sum[NW:1];
    assign mid_addr = mid[AW-1:0];
    assign result  = hi_reg;

    // Ordered compare: flipping the sign bit maps signed order onto unsigned
    assign flip    = ctl.key_signed ? KEY_TOP : '0;
    assign key_x   = key ^ flip;
    assign rd_x    = rd_key ^ flip;
    assign go_left = ctl.strict ? (key_x < rd_x) : !(rd_x < key_x);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= '0;
            hi_reg <= '0;
        end else if (ctl.init) begin
            lo_reg <= '0;
            hi_reg <= n;
        end else if (ctl.upd) begin
            if (go_left) begin
                hi_reg <= mid;
            end else begin
                lo_reg <= mid + {{(NW-1){1'b0}}, 1'b1};
            end
        end
    end

    a_window_order: assert property (@(posedge aclk) disable iff (!aresetn)
        hi_reg >= lo_reg)
        else $error("bisection window inverted");

    a_upd_active: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.upd |-> active)
        else $error("key read returned to a finished search");

    a_mid_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        active |-> (mid < hi_reg))
        else $error("probe index outside search window");

endmodule

// ===== design/sorted_key_range_search.sv =====
// Sorted key range search. Load words (tuser = 0) write one key per cycle into a
// table RAM; query words (tuser = 1) return the first index whose key is >= the
// start key and the last index whose key is <= the end key, or -1 for both when
// the range misses the table. A query reads the first and last keys, then runs
// the two bisections interleaved on the single RAM read port, one probe per
// cycle while both still search, each probe reading the RAM, then comparing the
// registered key. No input word is taken while a query is in progress or while a
// finished query waits for the result register to free up.
module sorted_key_range_search #(
    parameter int TABLE_DEPTH = skrs_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = skrs_pkg::KEY_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // entry_index, entry_key, range_start, range_end (lowest bits first)
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [skrs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [skrs_pkg::OP_W-1:0]       s_tuser,   // op
    // first_index, last_index (lowest bits first)
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [skrs_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [skrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [skrs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import skrs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam logic [KEY_WIDTH-1:0] KEY_TOP = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    // Configuration registers
    logic [CNT_W-1:0] count_reg;
    logic             signed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            signed_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RECORD_COUNT: count_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_KEY_SIGNED:   signed_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Input word unpacking
    logic                        s_accept;
    logic [IDX_W-1:0]            s_entry_index;
    logic [FKEY_W-1:0]           s_entry_key, s_range_start, s_range_end;
    logic [FKEY_W+KEY_WIDTH-1:0] ekey_wide, rsta_wide, rend_wide;
    logic [IDX_W+AW-1:0]         idx_wide;
    logic [CNT_W+NW-1:0]         cnt_wide;

    assign s_accept      = s_tvalid && s_tready;
    assign s_entry_index = s_tdata[IDX_LSB +: IDX_W];
    assign s_entry_key   = s_tdata[EKEY_LSB +: FKEY_W];
    assign s_range_start = s_tdata[RSTA_LSB +: FKEY_W];
    assign s_range_end   = s_tdata[REND_LSB +: FKEY_W];
    assign ekey_wide     = {{KEY_WIDTH{1'b0}}, s_entry_key};
    assign rsta_wide     = {{KEY_WIDTH{1'b0}}, s_range_start};
    assign rend_wide     = {{KEY_WIDTH{1'b0}}, s_range_end};
    assign idx_wide      = {{AW{1'b0}}, s_entry_index};
    assign cnt_wide      = {{NW{1'b0}}, count_reg};

    // Query context
    state_t               state_reg, state_next;
    logic [KEY_WIDTH-1:0] ks_reg, ke_reg;
    logic [NW-1:0]        n_reg, n_last;
    logic                 below_reg, hit_reg, turn_reg, pend_reg, psel_reg;

    // RAM
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    assign ram_we = s_accept && (s_tuser == OP_LOAD) && (32'(s_entry_index) < TABLE_DEPTH);

    skrs_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_wide[AW-1:0]),
        .wdata (ekey_wide[KEY_WIDTH-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Bisection units: a finds the start bound, b the end bound
    bctl_t         ctl_a, ctl_b;
    logic          a_active, b_active;
    logic [AW-1:0] a_mid, b_mid;
    logic [NW-1:0] a_res, b_res;

    skrs_bisect #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_bisect_first (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl_a),
        .n        (n_reg),
        .key      (ks_reg),
        .rd_key   (ram_rdata),
        .active   (a_active),
        .mid_addr (a_mid),
        .result   (a_res)
    );

    skrs_bisect #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_bisect_last (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl_b),
        .n        (n_reg),
        .key      (ke_reg),
        .rd_key   (ram_rdata),
        .active   (b_active),
        .mid_addr (b_mid),
        .result   (b_res)
    );

    // Edge compares against the first and last keys
    logic [KEY_WIDTH-1:0] flip, ks_x, ke_x, rd_x;
    logic                 ke_below_rd, rd_below_ks, miss, out_free, out_load;
    logic                 issue_a, issue_b;

    assign flip        = signed_reg ? KEY_TOP : '0;
    assign ks_x        = ks_reg ^ flip;
    assign ke_x        = ke_reg ^ flip;
    assign rd_x        = ram_rdata ^ flip;
    assign ke_below_rd = ke_x < rd_x;
    assign rd_below_ks = rd_x < ks_x;
    assign miss        = (n_reg == '0) || below_reg || rd_below_ks;
    assign n_last      = n_reg - {{(NW-1){1'b0}}, 1'b1};
    assign out_free    = !m_tvalid || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_tuser == OP_QUERY)) begin
                    state_next = ST_EDGE0;
                end
            end
            ST_EDGE0: state_next = ST_EDGE1;
            ST_EDGE1: state_next = ST_EDGE2;
            ST_EDGE2: state_next = miss ? ST_DONE : ST_SEARCH;
            ST_SEARCH: begin
                if (!a_active && !b_active && !pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready   = 1'b0;
        ram_raddr  = '0;
        issue_a    = 1'b0;
        issue_b    = 1'b0;
        out_load   = 1'b0;
        ctl_a      = '{init: 1'b0, upd: 1'b0, strict: 1'b0, key_signed: signed_reg};
        ctl_b      = '{init: 1'b0, upd: 1'b0, strict: 1'b1, key_signed: signed_reg};
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_EDGE0: ram_raddr = '0;
            ST_EDGE1: ram_raddr = n_last[AW-1:0];
            ST_EDGE2: begin
                ctl_a.init = !miss;
                ctl_b.init = !miss;
            end
            ST_SEARCH: begin
                issue_a   = !turn_reg && a_active;
                issue_b   = turn_reg && b_active;
                ram_raddr = turn_reg ? b_mid : a_mid;
                ctl_a.upd = pend_reg && !psel_reg;
                ctl_b.upd = pend_reg && psel_reg;
            end
            ST_DONE:  out_load = out_free;
            default:  ;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            turn_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            psel_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            below_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_EDGE1: below_reg <= ke_below_rd;
                ST_EDGE2: begin
                    hit_reg  <= !miss;
                    turn_reg <= 1'b0;
                    pend_reg <= 1'b0;
                end
                ST_SEARCH: begin
                    turn_reg <= !turn_reg;
                    pend_reg <= issue_a || issue_b;
                    psel_reg <= turn_reg;
                end
                default: ;
            endcase
        end
    end

    // Query payload capture
    always_ff @(posedge aclk) begin
        if (s_accept && (s_tuser == OP_QUERY)) begin
            ks_reg <= rsta_wide[KEY_WIDTH-1:0];
            ke_reg <= rend_wide[KEY_WIDTH-1:0];
            n_reg  <= (32'(count_reg) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : cnt_wide[NW-1:0];
        end
    end

    // Result register
    logic [NW+RES_W-1:0] a_wide, b_wide;
    logic [RES_W-1:0]    first_val, last_val, first_reg, last_reg;
    logic                m_tvalid_reg;

    assign a_wide    = {{RES_W{1'b0}}, a_res};
    assign b_wide    = {{RES_W{1'b0}}, b_res};
    assign first_val = hit_reg ? a_wide[RES_W-1:0] : '1;
    assign last_val  = hit_reg ? (b_wide[RES_W-1:0] - {{(RES_W-1){1'b0}}, 1'b1}) : '1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            first_reg <= first_val;
            last_reg  <= last_val;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-2*RES_W){1'b0}}, last_reg, first_reg};

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("table write during a query");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside completion");

    a_pending_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH && pend_reg) |=> (state_reg == ST_SEARCH))
        else $error("search left with a key read outstanding");

endmodule

// ===== sim/sorted_key_range_search_test.sv =====
`timescale 1ns / 1ps
// Self-checking test of sorted_key_range_search: loads sorted key tables, runs range
// queries and compares each result word with a built-in predictor of both bounds.
// Depends on skrs_pkg and the sorted_key_range_search RTL only.
module sorted_key_range_search_test;
    import skrs_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 500;
    localparam int SETTLE_WAIT  = 40;
    localparam int RANDOM_QUERIES = 360;

    // Tracks the key table and registers, predicts first/last index per query
    class bound_checker;
        bit [FKEY_W-1:0] key_table [TABLE_DEPTH_DEF];
        bit [CNT_W-1:0]  record_count;
        bit              key_signed;
        bit [RES_W-1:0]  due_first [$];
        bit [RES_W-1:0]  due_last [$];
        int              errors;

        function new();
            record_count = '0;
            key_signed   = 1'b1;
            errors       = 0;
        endfunction

        function void note_config(cfg_reg_t idx, bit [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_RECORD_COUNT: record_count = value[CNT_W-1:0];
                CFG_KEY_SIGNED:   key_signed   = value[0];
                default: ;
            endcase
        endfunction

        function bit key_below(bit [FKEY_W-1:0] a, bit [FKEY_W-1:0] b);
            if (key_signed)
                return $signed(a) < $signed(b);
            return a < b;
        endfunction

        // Bisection: smallest index whose key is >= k (or > k when strict), n if none
        function int bisect(int n, bit [FKEY_W-1:0] k, bit strict);
            int lo;
            int hi;
            int mid;
            bit go_left;
            lo = -1;
            hi = n;
            while (hi - lo > 1) begin
                mid = (hi + lo) / 2;
                go_left = strict ? key_below(k, key_table[mid])
                                 : !key_below(key_table[mid], k);
                if (go_left)
                    hi = mid;
                else
                    lo = mid;
            end
            return hi;
        endfunction

        function void note_word(op_t op, bit [IDX_W-1:0] idx, bit [FKEY_W-1:0] key,
                                bit [FKEY_W-1:0] lo_key, bit [FKEY_W-1:0] hi_key);
            int n;
            int first_pos;
            int last_pos;
            if (op == OP_LOAD) begin
                key_table[idx] = key;
                return;
            end
            n = (record_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : record_count;
            first_pos = -1;
            last_pos  = -1;
            if (n > 0 && !key_below(hi_key, key_table[0]) &&
                !key_below(key_table[n-1], lo_key)) begin
                first_pos = bisect(n, lo_key, 1'b0);
                last_pos  = bisect(n, hi_key, 1'b1) - 1;
            end
            due_first.push_back(first_pos[RES_W-1:0]);
            due_last.push_back(last_pos[RES_W-1:0]);
        endfunction

        function void check_word(bit [M_TDATA_W-1:0] word);
            bit [RES_W-1:0] want_first;
            bit [RES_W-1:0] want_last;
            bit [RES_W-1:0] got_first;
            bit [RES_W-1:0] got_last;
            got_first = word[FIRST_LSB +: RES_W];
            got_last  = word[LAST_LSB +: RES_W];
            if (due_first.size() == 0) begin
                $display("%0t: unexpected result word, first_index %0d last_index %0d",
                         $time, $signed(got_first), $signed(got_last));
                errors++;
                return;
            end
            want_first = due_first.pop_front();
            want_last  = due_last.pop_front();
            if (got_first !== want_first) begin
                $display("%0t: first_index expected %0d, got %0d",
                         $time, $signed(want_first), $signed(got_first));
                errors++;
            end
            if (got_last !== want_last) begin
                $display("%0t: last_index expected %0d, got %0d",
                         $time, $signed(want_last), $signed(got_last));
                errors++;
            end
        endfunction

        function int pending();
            return due_first.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;    // entry_index, entry_key, range_start, range_end
    logic [OP_W-1:0]       s_tuser = '0;    // op
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // first_index, last_index
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    bound_checker    sb;
    int              idle_pct = 0;
    int              stall_pct = 0;
    int              hold_reqs = 0;
    int              hold_seen = 0;
    int              hold_left = 0;
    int              cycle_count = 0;
    int              queries_sent = 0;
    bit              cur_signed = 1'b1;
    bit [FKEY_W-1:0] sorted_keys [$];

    sorted_key_range_search uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Monitors: accepted input words, config writes, accepted result words
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we)
                sb.note_config(cfg_reg_t'(cfg_index), cfg_wdata);
            if (s_tvalid && s_tready)
                sb.note_word(op_t'(s_tuser), s_tdata[IDX_LSB +: IDX_W],
                             s_tdata[EKEY_LSB +: FKEY_W], s_tdata[RSTA_LSB +: FKEY_W],
                             s_tdata[REND_LSB +: FKEY_W]);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Register write, only called while the block is idle
    task automatic write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one word, with an optional idle gap first; returns once accepted
    task automatic send_word(op_t op, bit [IDX_W-1:0] idx, bit [FKEY_W-1:0] key,
                             bit [FKEY_W-1:0] lo_key, bit [FKEY_W-1:0] hi_key);
        bit [S_TDATA_W-1:0] word;
        int gap;
        word = '0;
        word[IDX_LSB +: IDX_W]   = idx;
        word[EKEY_LSB +: FKEY_W] = key;
        word[RSTA_LSB +: FKEY_W] = lo_key;
        word[REND_LSB +: FKEY_W] = hi_key;
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering, wait for every pending result, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic query(bit [FKEY_W-1:0] lo_key, bit [FKEY_W-1:0] hi_key);
        send_word(OP_QUERY, IDX_W'($urandom_range(0, 1023)), $urandom, lo_key, hi_key);
        queries_sent++;
    endtask

    // Ascending keys under the chosen ordering; dense spans give duplicates
    task automatic build_table(int n, bit signed_order);
        bit [FKEY_W-1:0] ord [$];
        bit [FKEY_W-1:0] base;
        int mode;
        base = $urandom;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
            if (mode == 0)
                ord.push_back($urandom);
            else if (mode == 1)
                ord.push_back(base + $urandom_range(0, 3 * n));
            else
                ord.push_back(base + $urandom_range(0, n / 2 + 1));
        end
        ord.sort();
        sorted_keys.delete();
        foreach (ord[i])
            sorted_keys.push_back(signed_order ? ord[i] ^ 32'h8000_0000 : ord[i]);
    endtask

    function automatic bit [FKEY_W-1:0] pick_bound();
        int c;
        c = $urandom_range(0, 11);
        if (sorted_keys.size() != 0 && c < 6)
            return sorted_keys[$urandom_range(0, sorted_keys.size() - 1)]
                   + $urandom_range(0, 4) - 2;
        case (c)
            7:  return 32'h0000_0000;
            8:  return 32'hFFFF_FFFF;
            9:  return 32'h8000_0000;
            10: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly ordered ranges; a few inverted ones and stray loads
    task automatic run_queries(int count);
        bit [FKEY_W-1:0] a;
        bit [FKEY_W-1:0] b;
        bit [FKEY_W-1:0] t;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(OP_LOAD, IDX_W'($urandom_range(0, 1023)), $urandom,
                          $urandom, $urandom);
            end else begin
                a = pick_bound();
                b = pick_bound();
                if ($urandom_range(0, 9) < 8 &&
                    (cur_signed ? $signed(a) > $signed(b) : a > b)) begin
                    t = a;
                    a = b;
                    b = t;
                end
                query(a, b);
            end
        end
    endtask

    initial begin
        int phase;
        int n;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table after reset
        query(32'h8000_0000, 32'h7FFF_FFFF);
        // Signed table with duplicates, plus a write to the top entry
        send_word(OP_LOAD, IDX_W'(0), 32'hFFFF_FF9C, '0, '0);
        send_word(OP_LOAD, IDX_W'(1), 32'hFFFF_FFFB, '0, '0);
        send_word(OP_LOAD, IDX_W'(2), 32'd7, '0, '0);
        send_word(OP_LOAD, IDX_W'(3), 32'd7, '0, '0);
        send_word(OP_LOAD, IDX_W'(4), 32'd1000, '0, '0);
        send_word(OP_LOAD, IDX_W'(1023), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        settle();
        write_reg(CFG_RECORD_COUNT, CFG_DATA_W'(5));
        write_reg(CFG_KEY_SIGNED, CFG_DATA_W'(1));
        query(32'h8000_0000, 32'h7FFF_FFFF);   // whole table
        query(32'h8000_0000, 32'h8000_0000);   // range before the first key
        query(32'h7FFF_FFFF, 32'h7FFF_FFFF);   // range after the last key
        query(32'd7, 32'd7);                   // duplicate keys
        query(32'd8, 32'd6);                   // inverted range
        query(32'hFFFF_FFFB, 32'd7);
        query(32'h0000_0000, 32'hFFFF_FFFF);   // inverted under signed order
        settle();
        // Same table compared unsigned: no longer sorted
        write_reg(CFG_KEY_SIGNED, CFG_DATA_W'(0));
        query(32'h0000_0000, 32'hFFFF_FFFF);
        query(32'd1000, 32'd1000);
        settle();

        // Random phases, each with its own table, ordering and idling mode
        phase = 0;
        while (queries_sent < RANDOM_QUERIES) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            if (phase == 3) begin
                // One deeper table for longer searches
                n = $urandom_range(150, 250);
            end else begin
                case ($urandom_range(0, 19))
                    0: n = 0;
                    1: n = 1;
                    2: n = 2;
                    default: n = $urandom_range(3, 40);
                endcase
            end
            cur_signed = 1'($urandom_range(0, 1));
            build_table(n, cur_signed);
            write_reg(CFG_RECORD_COUNT, CFG_DATA_W'(n));
            write_reg(CFG_KEY_SIGNED, CFG_DATA_W'(cur_signed));
            foreach (sorted_keys[i])
                send_word(OP_LOAD, IDX_W'(i), sorted_keys[i], $urandom, $urandom);
            // Long result hold-off while queries keep coming
            if (phase == 2)
                hold_reqs <= hold_reqs + 1;
            run_queries($urandom_range(20, 60));
            settle();
            phase++;
        end

        settle();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
